>>> sv/assert_macros.svh
// assertion macros used by the parser rtl
// no dependencies; checks vanish when SYNTH is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define NMRP_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("nmrp assertion failed");
`define NMRP_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("nmrp assertion failed");
`else
`define NMRP_ASSERT(lbl, clk, rstn, prop)
`define NMRP_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

>>> sv/nmrp_pkg.sv
// shared constants and types of the file record parser
// no dependencies
`timescale 1ns / 1ps
package nmrp_pkg;
    localparam int DEF_RECORD_BYTES   = 1024;
    localparam int DEF_NAME_MAX_CHARS = 32;
    localparam int DEF_MAX_CHILDREN   = 32;
    localparam int DEF_MAX_ATTRIBUTES = 16;

    // wide enough for every offset the walk can form
    localparam int ADDR_W = 17;

    localparam logic [1:0] KIND_CHILD   = 2'd0;
    localparam logic [1:0] KIND_NAME    = 2'd1;
    localparam logic [1:0] KIND_SUMMARY = 2'd2;

    localparam logic [7:0] ATTR_FILE_NAME  = 8'h30;
    localparam logic [7:0] ATTR_INDEX_ROOT = 8'h90;
    localparam logic [7:0] ATTR_END        = 8'hFF;

    localparam logic [ADDR_W-1:0] FIX0_ADDR = ADDR_W'(510);
    localparam logic [ADDR_W-1:0] FIX1_ADDR = ADDR_W'(1022);

    typedef struct packed {
        logic short_rec;
    } t_job;
endpackage

>>> sv/ntfs_mft_record_parser_core.sv
// top level of the file record parser
// depends on nmrp_pkg, nmrp_front, nmrp_queue, nmrp_back
`timescale 1ns / 1ps
// usage
// - input channel: one record byte per transfer, taken when start is high and busy is low;
//   record_end marks the final byte of a record
// - bytes load one per cycle into the record store while busy is low; bytes past the record size are dropped
// - on record_end the loader posts a job into a two-entry queue and busy rises
// - the walker then reads the store one byte at a time: job pop, header and fixup,
//   then each attribute with its children, then the name characters,
//   bounded by the attribute limit and child limit
// - a short record skips the walk and gives only the summary, with the walk error set
// - results appear on o_result_valid for one cycle each: children, name chunks,
//   then the summary with o_last_result set; the receiver cannot stall
// - busy drops as the summary appears; the next record's bytes are taken only then, so
//   loading and walking of records do not overlap
// - reset clears the byte count, the queue and the walker; store contents are not cleared
module ntfs_mft_record_parser_core #(
    parameter int RECORD_BYTES   = nmrp_pkg::DEF_RECORD_BYTES,
    parameter int NAME_MAX_CHARS = nmrp_pkg::DEF_NAME_MAX_CHARS,
    parameter int MAX_CHILDREN   = nmrp_pkg::DEF_MAX_CHILDREN,
    parameter int MAX_ATTRIBUTES = nmrp_pkg::DEF_MAX_ATTRIBUTES
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [7:0]         i_data_byte,
    input  logic               i_record_end,
    output logic               o_result_valid,
    output logic [1:0]         o_result_kind,
    output logic [1:0]         o_record_kind,
    output logic [15:0]        o_used_size,
    output logic signed [16:0] o_parent_ref,
    output logic [7:0]         o_name_length,
    output logic [5:0]         o_child_count,
    output logic [63:0]        o_payload,
    output logic               o_name_truncated,
    output logic               o_children_dropped,
    output logic               o_walk_error,
    output logic               o_last_result
);
    import nmrp_pkg::*;
    localparam int IDX_W = $clog2(RECORD_BYTES);

    logic             wr_en, push, pop, job_valid, back_busy;
    logic [IDX_W-1:0] wr_addr;
    logic [7:0]       wr_data;
    t_job             push_job, head_job;

    // hold off the loader while a record waits or is being walked
    assign busy = job_valid || back_busy;

    nmrp_front #(.RECORD_BYTES(RECORD_BYTES)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_busy(busy),
        .i_data_byte(i_data_byte), .i_record_end(i_record_end),
        .o_wr_en(wr_en), .o_wr_addr(wr_addr), .o_wr_data(wr_data),
        .o_push(push), .o_job(push_job)
    );

    nmrp_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_job(push_job),
        .i_pop(pop), .o_valid(job_valid), .o_job(head_job)
    );

    nmrp_back #(
        .RECORD_BYTES(RECORD_BYTES), .NAME_MAX_CHARS(NAME_MAX_CHARS),
        .MAX_CHILDREN(MAX_CHILDREN), .MAX_ATTRIBUTES(MAX_ATTRIBUTES)
    ) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_wr_en(wr_en), .i_wr_addr(wr_addr), .i_wr_data(wr_data),
        .i_job_valid(job_valid), .i_job(head_job), .o_job_pop(pop), .o_busy(back_busy),
        .o_result_valid(o_result_valid), .o_result_kind(o_result_kind),
        .o_record_kind(o_record_kind), .o_used_size(o_used_size),
        .o_parent_ref(o_parent_ref), .o_name_length(o_name_length),
        .o_child_count(o_child_count), .o_payload(o_payload),
        .o_name_truncated(o_name_truncated), .o_children_dropped(o_children_dropped),
        .o_walk_error(o_walk_error), .o_last_result(o_last_result)
    );
endmodule

>>> sv/nmrp_front.sv
// byte loader: counts record bytes, drives the store write port, posts a job
// depends on nmrp_pkg
`timescale 1ns / 1ps
module nmrp_front #(
    parameter int RECORD_BYTES = nmrp_pkg::DEF_RECORD_BYTES
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic                              i_busy,
    input  logic [7:0]                        i_data_byte,
    input  logic                              i_record_end,
    output logic                              o_wr_en,
    output logic [$clog2(RECORD_BYTES)-1:0]   o_wr_addr,
    output logic [7:0]                        o_wr_data,
    output logic                              o_push,
    output nmrp_pkg::t_job                    o_job
);
    import nmrp_pkg::*;
    localparam int POS_W = $clog2(RECORD_BYTES + 1);
    localparam int IDX_W = $clog2(RECORD_BYTES);

    logic [POS_W-1:0] r_pos, n_pos, pos_after;
    logic             accept;

    assign accept    = i_start && !i_busy;
    assign o_wr_en   = accept && (r_pos < POS_W'(RECORD_BYTES));
    assign o_wr_addr = r_pos[IDX_W-1:0];
    assign o_wr_data = i_data_byte;
    assign pos_after = r_pos + POS_W'(o_wr_en);
    assign o_push    = accept && i_record_end;
    assign o_job.short_rec = pos_after < POS_W'(RECORD_BYTES);

    always_comb begin
        n_pos = r_pos;
        if (accept) begin
            n_pos = i_record_end ? '0 : pos_after;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else begin
            r_pos <= n_pos;
        end
    end
endmodule

>>> sv/nmrp_queue.sv
// two-entry job queue between loader and walker
// depends on nmrp_pkg
`timescale 1ns / 1ps
module nmrp_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  nmrp_pkg::t_job i_job,
    input  logic           i_pop,
    output logic           o_valid,
    output nmrp_pkg::t_job o_job
);
    import nmrp_pkg::*;
    t_job       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       do_push, do_pop;

    assign do_push = i_push && (r_cnt != 2'd2);
    assign do_pop  = i_pop && (r_cnt != 2'd0);
    assign o_valid = r_cnt != 2'd0;
    assign o_job   = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_q[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) r_wp <= ~r_wp;
            if (do_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(do_push) - 2'(do_pop);
        end
    end
endmodule

>>> sv/nmrp_back.sv
// record store and attribute walker; emits children, name chunks, summary
// depends on nmrp_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"
module nmrp_back #(
    parameter int RECORD_BYTES   = nmrp_pkg::DEF_RECORD_BYTES,
    parameter int NAME_MAX_CHARS = nmrp_pkg::DEF_NAME_MAX_CHARS,
    parameter int MAX_CHILDREN   = nmrp_pkg::DEF_MAX_CHILDREN,
    parameter int MAX_ATTRIBUTES = nmrp_pkg::DEF_MAX_ATTRIBUTES
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_wr_en,
    input  logic [$clog2(RECORD_BYTES)-1:0] i_wr_addr,
    input  logic [7:0]                      i_wr_data,
    input  logic                            i_job_valid,
    input  nmrp_pkg::t_job                  i_job,
    output logic                            o_job_pop,
    output logic                            o_busy,
    output logic                            o_result_valid,
    output logic [1:0]                      o_result_kind,
    output logic [1:0]                      o_record_kind,
    output logic [15:0]                     o_used_size,
    output logic signed [16:0]              o_parent_ref,
    output logic [7:0]                      o_name_length,
    output logic [5:0]                      o_child_count,
    output logic [63:0]                     o_payload,
    output logic                            o_name_truncated,
    output logic                            o_children_dropped,
    output logic                            o_walk_error,
    output logic                            o_last_result
);
    import nmrp_pkg::*;
    localparam int IDX_W = $clog2(RECORD_BYTES);
    localparam int NC_W  = $clog2(NAME_MAX_CHARS + 1);
    localparam int AC_W  = $clog2(MAX_ATTRIBUTES + 1);
    localparam int LW    = (NC_W > 8) ? NC_W + 1 : 9;
    localparam logic [ADDR_W-1:0] RB_A = ADDR_W'(RECORD_BYTES);

    localparam logic [4:0] S_IDLE = 5'd0,  S_H0 = 5'd1,   S_H1 = 5'd2,   S_H2 = 5'd3;
    localparam logic [4:0] S_H3 = 5'd4,    S_H4 = 5'd5,   S_H5 = 5'd6,   S_H6 = 5'd7;
    localparam logic [4:0] S_X0 = 5'd8,    S_X1 = 5'd9,   S_X2 = 5'd10,  S_X3 = 5'd11;
    localparam logic [4:0] S_WCHK = 5'd12, S_WT = 5'd13,  S_WS0 = 5'd14, S_WS1 = 5'd15;
    localparam logic [4:0] S_FLEN = 5'd16, S_FP0 = 5'd17, S_FP1 = 5'd18, S_I9 = 5'd19;
    localparam logic [4:0] S_ILO = 5'd20,  S_IHI = 5'd21, S_IST = 5'd22, S_NISS = 5'd23;
    localparam logic [4:0] S_NTAK = 5'd24, S_SUM = 5'd25;

    // record store, registered read
    logic [7:0]        mem [RECORD_BYTES];
    logic [7:0]        r_mq;
    logic [ADDR_W-1:0] r_aq, n_addr;
    logic [7:0]        b;

    logic [4:0]         r_state, n_state;
    logic [15:0]        r_usa, n_usa, r_fix0, n_fix0, r_fix1, n_fix1, r_used, n_used;
    logic [1:0]         r_fix_en, n_fix_en, r_rkind, n_rkind;
    logic [ADDR_W-1:0]  r_off, n_off, r_ref, n_ref, r_name_off, n_name_off;
    logic [7:0]         r_tmp, n_tmp, r_type, n_type, r_len, n_len;
    logic [15:0]        r_size, n_size;
    logic [AC_W-1:0]    r_acount, n_acount;
    logic [5:0]         r_children, n_children;
    logic signed [16:0] r_parent, n_parent;
    logic               r_err_walk, n_err_walk, r_err_drop, n_err_drop;
    logic               r_err_trunc, n_err_trunc;
    logic [NC_W-1:0]    r_nc, n_nc;
    logic [63:0]        r_chunk, n_chunk;
    logic [LW-1:0]      stored;
    logic [ADDR_W-1:0]  size_a;
    logic               emit_child, emit_name, emit_sum;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        r_mq <= mem[n_addr[IDX_W-1:0]];
        r_aq <= n_addr;
    end

    // bytes past the record read as zero; sector tails read their fixups
    always_comb begin
        if (r_aq >= RB_A) begin
            b = 8'h00;
        end else if (r_fix_en[0] && r_aq == FIX0_ADDR) begin
            b = r_fix0[7:0];
        end else if (r_fix_en[0] && r_aq == FIX0_ADDR + ADDR_W'(1)) begin
            b = r_fix0[15:8];
        end else if (r_fix_en[1] && r_aq == FIX1_ADDR) begin
            b = r_fix1[7:0];
        end else if (r_fix_en[1] && r_aq == FIX1_ADDR + ADDR_W'(1)) begin
            b = r_fix1[15:8];
        end else begin
            b = r_mq;
        end
    end

    assign stored = (LW'(r_len) < LW'(NAME_MAX_CHARS)) ? LW'(r_len) : LW'(NAME_MAX_CHARS);
    assign size_a = ADDR_W'(r_size);
    assign o_job_pop = (r_state == S_IDLE) && i_job_valid;
    assign o_busy    = r_state != S_IDLE;

    always_comb begin
        n_state = r_state;     n_addr = r_aq;         n_usa = r_usa;
        n_fix0 = r_fix0;       n_fix1 = r_fix1;       n_fix_en = r_fix_en;
        n_used = r_used;       n_rkind = r_rkind;     n_off = r_off;
        n_ref = r_ref;         n_name_off = r_name_off;
        n_tmp = r_tmp;         n_type = r_type;       n_len = r_len;
        n_size = r_size;       n_acount = r_acount;   n_children = r_children;
        n_parent = r_parent;   n_err_walk = r_err_walk;
        n_err_drop = r_err_drop; n_err_trunc = r_err_trunc;
        n_nc = r_nc;           n_chunk = r_chunk;
        emit_child = 1'b0;     emit_name = 1'b0;      emit_sum = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_job_valid) begin
                    n_parent = -17'sd1;  n_len = 8'h00;    n_children = '0;
                    n_err_walk = 1'b0;   n_err_drop = 1'b0; n_err_trunc = 1'b0;
                    n_fix_en = 2'b00;    n_acount = '0;    n_rkind = 2'd0;
                    n_used = 16'h0000;   n_nc = '0;        n_chunk = '0;
                    if (i_job.short_rec) begin
                        n_err_walk = 1'b1;
                        n_state = S_SUM;
                    end else begin
                        n_addr = ADDR_W'(4);
                        n_state = S_H0;
                    end
                end
            end
            S_H0: begin n_usa[7:0] = b;  n_addr = ADDR_W'(5);  n_state = S_H1; end
            S_H1: begin n_usa[15:8] = b; n_addr = ADDR_W'(20); n_state = S_H2; end
            S_H2: begin n_off = ADDR_W'(b); n_addr = ADDR_W'(21); n_state = S_H3; end
            S_H3: begin
                n_off = ADDR_W'({b, r_off[7:0]});
                n_addr = ADDR_W'(22);
                n_state = S_H4;
            end
            S_H4: begin
                n_rkind = (b <= 8'd2) ? b[1:0] : 2'd3;
                n_addr = ADDR_W'(24);
                n_state = S_H5;
            end
            S_H5: begin n_used[7:0] = b; n_addr = ADDR_W'(25); n_state = S_H6; end
            S_H6: begin
                n_used[15:8] = b;
                n_addr = ADDR_W'(r_usa) + ADDR_W'(2);
                n_state = S_X0;
            end
            S_X0: begin
                n_fix0[7:0] = b;
                n_addr = ADDR_W'(r_usa) + ADDR_W'(3);
                n_state = S_X1;
            end
            S_X1: begin
                n_fix0[15:8] = b;
                n_fix_en[0] = (ADDR_W'(r_usa) + ADDR_W'(3)) < RB_A;
                n_addr = ADDR_W'(r_usa) + ADDR_W'(4);
                n_state = S_X2;
            end
            S_X2: begin
                n_fix1[7:0] = b;
                n_addr = ADDR_W'(r_usa) + ADDR_W'(5);
                n_state = S_X3;
            end
            S_X3: begin
                n_fix1[15:8] = b;
                n_fix_en[1] = (ADDR_W'(r_usa) + ADDR_W'(5)) < RB_A;
                n_state = S_WCHK;
            end
            S_WCHK: begin
                if (r_off + ADDR_W'(4) > RB_A) begin
                    n_err_walk = 1'b1;
                    n_state = S_NISS;
                end else begin
                    n_addr = r_off;
                    n_state = S_WT;
                end
            end
            S_WT: begin
                n_type = b;
                if (b == ATTR_END) begin
                    n_state = S_NISS;
                end else if (r_off + ADDR_W'(6) > RB_A) begin
                    n_err_walk = 1'b1;
                    n_state = S_NISS;
                end else begin
                    n_addr = r_off + ADDR_W'(4);
                    n_state = S_WS0;
                end
            end
            S_WS0: begin n_tmp = b; n_addr = r_off + ADDR_W'(5); n_state = S_WS1; end
            S_WS1: begin
                n_size = {b, r_tmp};
                if ({b, r_tmp} == 16'h0000 ||
                    r_off + ADDR_W'({b, r_tmp}) > RB_A ||
                    r_acount >= AC_W'(MAX_ATTRIBUTES)) begin
                    n_err_walk = 1'b1;
                    n_state = S_NISS;
                end else begin
                    n_acount = r_acount + AC_W'(1);
                    if (r_type == ATTR_FILE_NAME) begin
                        n_addr = r_off + ADDR_W'(88);
                        n_state = S_FLEN;
                    end else if (r_type == ATTR_INDEX_ROOT) begin
                        n_addr = r_off + ADDR_W'(9);
                        n_state = S_I9;
                    end else begin
                        n_off = r_off + ADDR_W'({b, r_tmp});
                        n_state = S_WCHK;
                    end
                end
            end
            S_FLEN: begin
                n_len = b;
                n_err_trunc = LW'(b) > LW'(NAME_MAX_CHARS);
                n_name_off = r_off;
                n_addr = r_off + ADDR_W'(24);
                n_state = S_FP0;
            end
            S_FP0: begin n_tmp = b; n_addr = r_off + ADDR_W'(25); n_state = S_FP1; end
            S_FP1: begin
                n_parent = signed'({1'b0, b, r_tmp});
                n_off = r_off + size_a;
                n_state = S_WCHK;
            end
            S_I9: begin
                // entries start past the header, node header and name area
                n_ref = r_off + ADDR_W'(56) + ADDR_W'({b, 1'b0});
                n_addr = r_off + ADDR_W'(56) + ADDR_W'({b, 1'b0});
                n_state = S_ILO;
            end
            S_ILO: begin
                if (b == 8'h00) begin
                    n_off = r_off + size_a;
                    n_state = S_WCHK;
                end else if (r_children >= 6'(MAX_CHILDREN)) begin
                    n_err_drop = 1'b1;
                    n_off = r_off + size_a;
                    n_state = S_WCHK;
                end else begin
                    n_tmp = b;
                    n_addr = r_ref + ADDR_W'(1);
                    n_state = S_IHI;
                end
            end
            S_IHI: begin
                emit_child = 1'b1;
                n_children = r_children + 6'd1;
                n_addr = r_ref + ADDR_W'(8);
                n_state = S_IST;
            end
            S_IST: begin
                if (b == 8'h00) begin
                    n_off = r_off + size_a;
                    n_state = S_WCHK;
                end else begin
                    n_ref = r_ref + ADDR_W'(b);
                    n_addr = r_ref + ADDR_W'(b);
                    n_state = S_ILO;
                end
            end
            S_NISS: begin
                if (LW'(r_nc) >= stored) begin
                    n_state = S_SUM;
                end else begin
                    n_addr = r_name_off + ADDR_W'(90) + ADDR_W'({r_nc, 1'b0});
                    n_state = S_NTAK;
                end
            end
            S_NTAK: begin
                n_chunk = r_chunk | (64'(b) << {r_nc[2:0], 3'b000});
                n_nc = r_nc + NC_W'(1);
                if (r_nc[2:0] == 3'd7 || LW'(r_nc) + LW'(1) == stored) begin
                    emit_name = 1'b1;
                end
                n_state = S_NISS;
            end
            S_SUM: begin
                emit_sum = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_result_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            o_result_valid <= emit_child || emit_name || emit_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        r_usa <= n_usa;       r_fix0 <= n_fix0;       r_fix1 <= n_fix1;
        r_fix_en <= n_fix_en; r_used <= n_used;       r_rkind <= n_rkind;
        r_off <= n_off;       r_ref <= n_ref;         r_name_off <= n_name_off;
        r_tmp <= n_tmp;       r_type <= n_type;       r_len <= n_len;
        r_size <= n_size;     r_acount <= n_acount;   r_children <= n_children;
        r_parent <= n_parent; r_err_walk <= n_err_walk;
        r_err_drop <= n_err_drop; r_err_trunc <= n_err_trunc;
        r_nc <= n_nc;
        r_chunk <= emit_name ? 64'h0 : n_chunk;
    end

    // result fields
    always_ff @(posedge i_clk) begin
        o_record_kind      <= r_rkind;
        o_used_size        <= r_used;
        o_result_kind      <= emit_sum ? KIND_SUMMARY : (emit_name ? KIND_NAME : KIND_CHILD);
        o_payload          <= emit_name ? n_chunk :
                              (emit_child ? {48'h0, b, r_tmp} : 64'h0);
        o_parent_ref       <= emit_sum ? r_parent : 17'sd0;
        o_name_length      <= emit_sum ? r_len : 8'h00;
        o_child_count      <= emit_sum ? r_children : 6'd0;
        o_name_truncated   <= emit_sum && r_err_trunc;
        o_children_dropped <= emit_sum && r_err_drop;
        o_walk_error       <= emit_sum && r_err_walk;
        o_last_result      <= emit_sum;
    end

    `NMRP_ASSERT(a_no_load_during_walk, i_clk, i_rst_n, i_wr_en |-> r_state == S_IDLE)
    `NMRP_ASSERT(a_last_is_summary, i_clk, i_rst_n, (o_result_valid && o_last_result) |-> o_result_kind == KIND_SUMMARY)
    `NMRP_ASSERT(a_child_bound, i_clk, i_rst_n, r_state != S_IDLE |-> r_children <= 6'(MAX_CHILDREN))
endmodule
